// File: rtl/bgc_pkg.sv
// Package for the button gesture classifier: request, result, per-button and
// confirm types, event and mode codes, register indexes and sizes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bgc_pkg;

  localparam int SLOT_BUTTONS    = 42;
  localparam int CONTROL_BUTTONS = 6;
  localparam int NUM_BUTTONS     = SLOT_BUTTONS + CONTROL_BUTTONS;
  localparam int IDX_W           = $clog2(NUM_BUTTONS);

  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 16;

  localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DOUBLE_PRESS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CONFIRM_WINDOW = 2'd2;

  localparam logic [CFG_W-1:0] LONG_PRESS_RESET     = 16'd500;
  localparam logic [CFG_W-1:0] DOUBLE_PRESS_RESET   = 16'd300;
  localparam logic [CFG_W-1:0] CONFIRM_WINDOW_RESET = 16'd2000;

  typedef enum logic [1:0] {
    MODE_IDLE     = 2'd0,
    MODE_PRESSED  = 2'd1,
    MODE_LONG     = 2'd2,
    MODE_RELEASED = 2'd3
  } bgc_mode_e;

  typedef enum logic [2:0] {
    EV_NONE      = 3'd0,
    EV_PRESS     = 3'd1,
    EV_RELEASE   = 3'd2,
    EV_LONG_ARM  = 3'd3,
    EV_LONG_CONF = 3'd4,
    EV_DOUBLE    = 3'd5,
    EV_SINGLE    = 3'd6
  } bgc_event_e;

  typedef struct packed {
    logic [5:0]  button_index;
    logic        pressed;
    logic [31:0] time_ms;
  } bgc_req_t;

  typedef struct packed {
    bgc_event_e  event_res;
    logic [5:0]  event_button;
    logic        is_control_button;
    logic        confirm_cancelled;
    logic        confirm_pending;
  } bgc_res_t;

  typedef struct packed {
    bgc_mode_e   mode;
    logic [31:0] press_start;
    logic        long_fired;
    logic [31:0] last_short;
  } bgc_entry_t;

  localparam bgc_entry_t ENTRY_RESET = '{
    mode:        MODE_IDLE,
    press_start: 32'd0,
    long_fired:  1'b0,
    last_short:  32'd0
  };

  typedef struct packed {
    logic        valid;
    logic [5:0]  button;
    logic [31:0] deadline;
  } bgc_confirm_t;

  typedef struct packed {
    logic [CFG_W-1:0] long_press_ms;
    logic [CFG_W-1:0] double_press_ms;
    logic [CFG_W-1:0] confirm_span_ms;
  } bgc_cfg_t;

endpackage

`default_nettype wire

// File: rtl/bgc_step.sv
// Combinational update for one request: confirm lapse and cancel, then the
// per-button machine. Depends on bgc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bgc_step (
  input  bgc_pkg::bgc_req_t     req_i,
  input  bgc_pkg::bgc_entry_t   entry_i,
  input  bgc_pkg::bgc_confirm_t confirm_i,
  input  bgc_pkg::bgc_cfg_t     cfg_i,
  output bgc_pkg::bgc_entry_t   entry_o,
  output logic                  entry_we_o,
  output bgc_pkg::bgc_confirm_t confirm_o,
  output bgc_pkg::bgc_res_t     res_o
);
  import bgc_pkg::*;

  logic        in_range;
  logic [31:0] lapse_diff;
  logic [31:0] hold_time;
  logic [31:0] gap_time;
  logic        lapsed;
  bgc_confirm_t cnf;
  logic        cancelled;
  bgc_entry_t  nxt;
  bgc_event_e  ev;

  assign in_range   = {1'b0, req_i.button_index} < 7'(NUM_BUTTONS);
  assign lapse_diff = req_i.time_ms - confirm_i.deadline;
  assign lapsed     = (lapse_diff != 32'd0) && !lapse_diff[31];
  assign hold_time  = req_i.time_ms - entry_i.press_start;
  assign gap_time   = req_i.time_ms - entry_i.last_short;

  always_comb begin
    cnf       = confirm_i;
    cancelled = 1'b0;
    nxt       = entry_i;
    ev        = EV_NONE;

    if (cnf.valid && lapsed) begin
      cnf.valid = 1'b0;
      cancelled = 1'b1;
    end
    if (cnf.valid && (req_i.button_index != cnf.button) && req_i.pressed) begin
      cnf.valid = 1'b0;
      cancelled = 1'b1;
    end

    unique case (entry_i.mode)
      MODE_IDLE: begin
        if (req_i.pressed) begin
          nxt.mode        = MODE_PRESSED;
          nxt.press_start = req_i.time_ms;
          nxt.long_fired  = 1'b0;
          ev              = EV_PRESS;
        end
      end
      MODE_PRESSED: begin
        if (!req_i.pressed) begin
          nxt.mode = MODE_RELEASED;
          ev       = EV_RELEASE;
        end else if (!entry_i.long_fired &&
                     (hold_time >= {16'd0, cfg_i.long_press_ms})) begin
          nxt.mode       = MODE_LONG;
          nxt.long_fired = 1'b1;
          cnf.valid      = 1'b1;
          cnf.button     = req_i.button_index;
          cnf.deadline   = req_i.time_ms + {16'd0, cfg_i.confirm_span_ms};
          ev             = EV_LONG_ARM;
        end
      end
      MODE_LONG: begin
        if (!req_i.pressed) begin
          nxt.mode = MODE_RELEASED;
          ev       = EV_RELEASE;
        end
      end
      MODE_RELEASED: begin
        // The level seen here is not acted on; the button simply returns to idle.
        nxt.mode = MODE_IDLE;
        if (!entry_i.long_fired) begin
          if (cnf.valid && (cnf.button == req_i.button_index)) begin
            cnf.valid = 1'b0;
            ev        = EV_LONG_CONF;
          end else if (gap_time < {16'd0, cfg_i.double_press_ms}) begin
            nxt.last_short = 32'd0;
            ev             = EV_DOUBLE;
          end else begin
            nxt.last_short = req_i.time_ms;
            ev             = EV_SINGLE;
          end
        end
      end
      default: begin
        nxt.mode = MODE_IDLE;
      end
    endcase

    // An index past the last button leaves every piece of state alone.
    if (!in_range) begin
      cnf       = confirm_i;
      cancelled = 1'b0;
      ev        = EV_NONE;
    end
  end

  assign entry_o    = nxt;
  assign entry_we_o = in_range;
  assign confirm_o  = cnf;

  assign res_o.event_res         = ev;
  assign res_o.event_button      = req_i.button_index;
  assign res_o.is_control_button = in_range &&
                                   ({1'b0, req_i.button_index} >= 7'(SLOT_BUTTONS));
  assign res_o.confirm_cancelled = cancelled;
  assign res_o.confirm_pending   = cnf.valid;

endmodule

`default_nettype wire

// File: rtl/button_gesture_classifier.sv
// Button gesture classifier: a request is held in the request stage with its entry,
// then its result in the result register; one request per cycle while the output
// does not stall, set by the single update pass between read and result registers.
// Reset (asynchronous, active low) returns every button to idle through per-entry
// valid bits, clears any pending confirm and loads the default hold, double and
// confirm times; there is no clearing pass, so requests are taken right away.
`timescale 1ns / 1ps
`default_nettype none

module button_gesture_classifier (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Configuration write port.
  input  logic                              cfg_we_i,
  input  logic [bgc_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [bgc_pkg::CFG_W-1:0]         cfg_wdata_i,
  // Request channel.
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  bgc_pkg::bgc_req_t                 in_req_i,
  // Result channel.
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output bgc_pkg::bgc_res_t                 out_res_o
);
  import bgc_pkg::*;

  // Configuration registers. The user is to write them only while the block is idle;
  // the block leaves this unenforced, and the update logic reads them directly.
  bgc_cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.long_press_ms   <= LONG_PRESS_RESET;
      cfg_q.double_press_ms <= DOUBLE_PRESS_RESET;
      cfg_q.confirm_span_ms <= CONFIRM_WINDOW_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_LONG_PRESS:     cfg_q.long_press_ms   <= cfg_wdata_i;
        REG_DOUBLE_PRESS:   cfg_q.double_press_ms <= cfg_wdata_i;
        REG_CONFIRM_WINDOW: cfg_q.confirm_span_ms <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Handshake. The request stage holds one request together with the button
  // entry read for it; the result register parts it from the output side.
  logic s1_valid_q;
  bgc_req_t s1_req_q;
  bgc_entry_t rd_q;
  logic out_valid_q;
  bgc_res_t out_q;
  logic out_ready;
  logic s1_fire;
  logic in_fire;

  assign out_ready  = !out_valid_q || !out_stall_i;
  assign s1_fire    = s1_valid_q && out_ready;
  assign in_stall_o = s1_valid_q && !out_ready;
  assign in_fire    = in_valid_i && !in_stall_o;

  // Per-button state: the entry memory plus a valid bit per button. A button
  // whose valid bit is clear reads as idle with zero times.
  bgc_entry_t entry_mem [NUM_BUTTONS];
  logic [NUM_BUTTONS-1:0] valid_q;

  // Update logic for the request in the request stage.
  bgc_confirm_t confirm_q;
  bgc_confirm_t confirm_d;
  bgc_entry_t wr_entry;
  logic wr_in_range;
  logic wr_en;
  logic [IDX_W-1:0] wr_idx;
  logic [IDX_W-1:0] rd_idx;
  logic rd_in_range;
  bgc_res_t res_d;

  bgc_step u_step (
    .req_i      (s1_req_q),
    .entry_i    (rd_q),
    .confirm_i  (confirm_q),
    .cfg_i      (cfg_q),
    .entry_o    (wr_entry),
    .entry_we_o (wr_in_range),
    .confirm_o  (confirm_d),
    .res_o      (res_d)
  );

  assign wr_en       = s1_fire && wr_in_range;
  assign wr_idx      = s1_req_q.button_index[IDX_W-1:0];
  assign rd_idx      = in_req_i.button_index[IDX_W-1:0];
  assign rd_in_range = {1'b0, in_req_i.button_index} < 7'(NUM_BUTTONS);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      entry_mem[wr_idx] <= wr_entry;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_en) begin
      valid_q[wr_idx] <= 1'b1;
    end
  end

  // Registered read for a newly accepted request. When the request ahead of
  // it writes the same button at this edge, the fresh entry is forwarded.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_req_q <= in_req_i;
      if (!rd_in_range) begin
        rd_q <= ENTRY_RESET;
      end else if (wr_en && (wr_idx == rd_idx)) begin
        rd_q <= wr_entry;
      end else if (!valid_q[rd_idx]) begin
        rd_q <= ENTRY_RESET;
      end else begin
        rd_q <= entry_mem[rd_idx];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_fire) begin
      s1_valid_q <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  // The single confirm slot commits together with the request's result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      confirm_q <= '0;
    end else if (s1_fire) begin
      confirm_q <= confirm_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      out_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;

  // A stall toward the requester only comes from a full request stage.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q)
    else $error("request stall raised with an empty request stage");

  // A request that leaves the request stage always shows up as a result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire |=> out_valid_q)
    else $error("committed request did not reach the result register");

  // The pending flag in a new result matches the committed confirm slot.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire |=> (out_q.confirm_pending == confirm_q.valid))
    else $error("confirm pending flag disagrees with the confirm slot");

  // A button written by the update is marked valid from then on.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |=> valid_q[$past(wr_idx)])
    else $error("written button entry not marked valid");

endmodule

`default_nettype wire

// File: tb/sv/testbench.sv
// Self-checking testbench for the button gesture classifier: directed and random
// button level samples, a built-in gesture predictor and an in-order result check.
// Depends on bgc_pkg and button_gesture_classifier from the RTL.
`timescale 1ns / 1ps

module testbench;
  import bgc_pkg::*;

  // Register index that the block decodes to nothing; writes to it must be ignored.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  localparam int unsigned PHASE_ITEMS  = 135;   // in-range samples per register setting
  localparam int unsigned NUM_PHASES   = 7;
  localparam int unsigned MAX_WAIT     = 13;    // longest gap or stall drawn per request
  localparam int unsigned DRAIN_CYCLES = 6;     // settle time after the queues run empty
  localparam int unsigned QUIET_LIMIT  = 1000;  // cycles without any handshake

  typedef struct {
    bgc_req_t    req;
    int unsigned gap;
  } level_sample_t;

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_W-1:0]     cfg_wdata_i = '0;
  logic     in_valid_i  = 1'b0;
  logic     in_stall_o;
  bgc_req_t in_req_i    = '0;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  bgc_res_t out_res_o;

  button_gesture_classifier uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_res_o   (out_res_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 0;
  end

  // Requests waiting to be driven and the gesture results they are expected to give.
  level_sample_t sample_queue[$];
  bgc_res_t      expected_events[$];

  // Predictor state: one entry per button, the single confirm slot and the registers.
  bgc_entry_t   btn_state [NUM_BUTTONS];
  bgc_confirm_t confirm_slot;
  bgc_cfg_t     active_cfg;

  logic [31:0]  clock_ms;          // time base used while building gestures
  bit           calm_phase;        // when set, neither side idles or stalls
  int unsigned  planned_count;     // in-range samples queued in the current phase
  int unsigned  gap_count;
  int unsigned  hold_left;
  int unsigned  stall_draw;
  int unsigned  quiet_cycles;
  int unsigned  fail_count;
  int unsigned  accepted_reqs;
  int unsigned  checked_results;
  int unsigned  event_tally [8];
  int unsigned  cancel_tally;

  // ---------------------------------------------------------------------------
  // Gesture predictor. It is run once per accepted request, in acceptance order,
  // and updates its own copy of the per-button machines and the confirm slot.
  // ---------------------------------------------------------------------------
  task automatic reset_predictor();
    for (int n = 0; n < NUM_BUTTONS; n++) begin
      btn_state[n] = ENTRY_RESET;
    end
    confirm_slot = '0;
    active_cfg.long_press_ms   = LONG_PRESS_RESET;
    active_cfg.double_press_ms = DOUBLE_PRESS_RESET;
    active_cfg.confirm_span_ms = CONFIRM_WINDOW_RESET;
  endtask

  function automatic bgc_res_t classify_sample(input bgc_req_t rq);
    bgc_res_t    res;
    int unsigned b;
    logic [31:0] lapse;
    logic [31:0] held;
    logic [31:0] since_short;
    res = '0;
    res.event_res    = EV_NONE;
    res.event_button = rq.button_index;
    b = rq.button_index;
    // An index past the last control button leaves all state alone.
    if (b >= NUM_BUTTONS) begin
      res.confirm_pending = confirm_slot.valid;
      return res;
    end
    // The deadline counts as lapsed when the time is 1 to 2^31-1 ms past it.
    lapse = rq.time_ms - confirm_slot.deadline;
    if (confirm_slot.valid && lapse != 32'd0 && !lapse[31]) begin
      confirm_slot.valid    = 1'b0;
      res.confirm_cancelled = 1'b1;
    end
    // Pressing any other button throws the pending confirm away.
    if (confirm_slot.valid && rq.button_index != confirm_slot.button && rq.pressed) begin
      confirm_slot.valid    = 1'b0;
      res.confirm_cancelled = 1'b1;
    end
    held        = rq.time_ms - btn_state[b].press_start;
    since_short = rq.time_ms - btn_state[b].last_short;
    case (btn_state[b].mode)
      MODE_IDLE: begin
        if (rq.pressed) begin
          btn_state[b].mode        = MODE_PRESSED;
          btn_state[b].press_start = rq.time_ms;
          btn_state[b].long_fired  = 1'b0;
          res.event_res            = EV_PRESS;
        end
      end
      MODE_PRESSED: begin
        if (!rq.pressed) begin
          btn_state[b].mode = MODE_RELEASED;
          res.event_res     = EV_RELEASE;
        end else if (!btn_state[b].long_fired && held >= {16'd0, active_cfg.long_press_ms}) begin
          btn_state[b].mode       = MODE_LONG;
          btn_state[b].long_fired = 1'b1;
          confirm_slot.valid      = 1'b1;
          confirm_slot.button     = rq.button_index;
          confirm_slot.deadline   = rq.time_ms + {16'd0, active_cfg.confirm_span_ms};
          res.event_res           = EV_LONG_ARM;
        end
      end
      MODE_LONG: begin
        if (!rq.pressed) begin
          btn_state[b].mode = MODE_RELEASED;
          res.event_res     = EV_RELEASE;
        end
      end
      default: begin
        // The released state always falls back to idle; the level is not looked at.
        btn_state[b].mode = MODE_IDLE;
        if (!btn_state[b].long_fired) begin
          if (confirm_slot.valid && confirm_slot.button == rq.button_index) begin
            confirm_slot.valid = 1'b0;
            res.event_res      = EV_LONG_CONF;
          end else if (since_short < {16'd0, active_cfg.double_press_ms}) begin
            btn_state[b].last_short = 32'd0;
            res.event_res           = EV_DOUBLE;
          end else begin
            btn_state[b].last_short = rq.time_ms;
            res.event_res           = EV_SINGLE;
          end
        end
      end
    endcase
    res.is_control_button = (b >= SLOT_BUTTONS);
    res.confirm_pending   = confirm_slot.valid;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers. Gestures are built ahead of time as timed level samples;
  // the predictor alone decides what each one should produce.
  // ---------------------------------------------------------------------------
  function automatic int unsigned draw_wait();
    if (calm_phase || $urandom_range(0, 1) == 0) return 0;
    return $urandom_range(1, MAX_WAIT);
  endfunction

  // Picks a value at, just below, below or above a threshold so that the
  // boundaries of the hold, double and confirm times are hit often.
  function automatic logic [31:0] near_value(input logic [31:0] x);
    case ($urandom_range(0, 3))
      0:       return (x == 32'd0) ? 32'd0 : x - 32'd1;
      1:       return x;
      2:       return $urandom_range(0, x);
      default: return x + $urandom_range(1, x + 1);
    endcase
  endfunction

  task automatic queue_sample(input int unsigned idx, input bit lvl, input logic [31:0] t);
    level_sample_t ls;
    ls.req.button_index = 6'(idx);
    ls.req.pressed      = lvl;
    ls.req.time_ms      = t;
    ls.gap              = draw_wait();
    sample_queue = {sample_queue, ls};
    if (idx < NUM_BUTTONS) planned_count++;
  endtask

  // A full tap: press, optional held sample, release, then the sample that lets
  // the machine leave the released state. The last one lands span ms from now.
  task automatic queue_tap(input int unsigned b, input logic [31:0] span);
    logic [31:0] t0;
    t0 = clock_ms;
    queue_sample(b, 1'b1, t0 + span / 4);
    if ($urandom_range(0, 3) == 0) queue_sample(b, 1'b1, t0 + span / 3);
    queue_sample(b, 1'b0, t0 + span / 2);
    clock_ms = t0 + span;
    queue_sample(b, $urandom_range(0, 1), clock_ms);
  endtask

  task automatic queue_directed();
    // Early double right after reset: the stored release time is still zero.
    queue_sample(0, 1'b1, 32'd10);
    queue_sample(0, 1'b0, 32'd50);
    queue_sample(0, 1'b0, 32'd60);
    // Long press armed exactly at the hold time, then confirmed by a short tap.
    queue_sample(5, 1'b1, 32'd2000);
    queue_sample(5, 1'b1, 32'd2500);
    queue_sample(5, 1'b0, 32'd2800);
    queue_sample(5, 1'b1, 32'd2900);
    queue_sample(5, 1'b1, 32'd3000);
    queue_sample(5, 1'b0, 32'd3050);
    queue_sample(5, 1'b0, 32'd3100);
    // Armed long press dropped by a press of the first control button.
    queue_sample(6, 1'b1, 32'd4000);
    queue_sample(6, 1'b1, 32'd4600);
    queue_sample(SLOT_BUTTONS, 1'b1, 32'd4700);
    queue_sample(SLOT_BUTTONS, 1'b0, 32'd4710);
    queue_sample(SLOT_BUTTONS, 1'b0, 32'd4720);
    queue_sample(6, 1'b0, 32'd4800);
    queue_sample(6, 1'b0, 32'd4900);
    // Confirm lapses one millisecond after the deadline; equal to it is not late.
    queue_sample(8, 1'b1, 32'd10000);
    queue_sample(8, 1'b1, 32'd10500);
    queue_sample(8, 1'b0, 32'd12500);
    queue_sample(8, 1'b0, 32'd12501);
    // Indexes past the last button are ignored.
    queue_sample(63, 1'b1, 32'hFFFF_FFFF);
    queue_sample(NUM_BUTTONS, 1'b0, 32'd0);
    // Hold time measured across the wrap of the millisecond counter.
    queue_sample(NUM_BUTTONS - 1, 1'b1, 32'hFFFF_FF00);
    queue_sample(NUM_BUTTONS - 1, 1'b1, 32'h0000_0100);
    queue_sample(NUM_BUTTONS - 1, 1'b0, 32'h0000_0110);
    clock_ms = 32'h0000_0200;
  endtask

  // One random gesture. Most are well-formed taps, doubles and long presses with
  // random timing; the rest are noise samples and broken sequences.
  task automatic queue_gesture();
    int unsigned kind;
    int unsigned b;
    int unsigned other;
    logic [31:0] lng;
    logic [31:0] dbl;
    logic [31:0] cw;
    logic [31:0] hold;
    logic [31:0] arm_t;
    logic [31:0] rem;
    lng   = {16'd0, active_cfg.long_press_ms};
    dbl   = {16'd0, active_cfg.double_press_ms};
    cw    = {16'd0, active_cfg.confirm_span_ms};
    kind  = $urandom_range(0, 19);
    b     = $urandom_range(0, NUM_BUTTONS - 1);
    other = (b + $urandom_range(1, NUM_BUTTONS - 1)) % NUM_BUTTONS;
    if (kind < 2) begin
      // Noise: any index, any level, and now and then a jump to any time at all.
      if ($urandom_range(0, 3) == 0) clock_ms = $urandom;
      else clock_ms = clock_ms + $urandom_range(0, 2 * lng + 2);
      queue_sample($urandom_range(0, 63), $urandom_range(0, 1), clock_ms);
    end else if (kind < 4) begin
      // Broken sequence: two different buttons with random levels.
      repeat ($urandom_range(3, 6)) begin
        clock_ms = clock_ms + $urandom_range(0, lng);
        queue_sample($urandom_range(0, 1) ? b : other, $urandom_range(0, 1), clock_ms);
      end
    end else if (kind < 9) begin
      clock_ms = clock_ms + $urandom_range(0, 2 * dbl + 1);
      queue_tap(b, $urandom_range(0, lng));
    end else if (kind < 14) begin
      // Double: the second tap ends near the double press gap after the first.
      queue_tap(b, $urandom_range(0, lng));
      queue_tap(b, near_value(dbl));
    end else begin
      // Long press, armed at or around the hold time.
      hold = near_value(lng);
      queue_sample(b, 1'b1, clock_ms);
      queue_sample(b, 1'b1, clock_ms + hold);
      if (hold < lng) begin
        hold = lng;
        queue_sample(b, 1'b1, clock_ms + hold);
      end
      arm_t = clock_ms + hold;
      if ($urandom_range(0, 2) == 0) queue_sample(b, 1'b1, arm_t + $urandom_range(0, 20));
      clock_ms = arm_t + $urandom_range(0, cw / 4);
      queue_sample(b, 1'b0, clock_ms);
      clock_ms = clock_ms + $urandom_range(0, 20);
      queue_sample(b, $urandom_range(0, 1), clock_ms);
      case ($urandom_range(0, 3))
        0, 1: begin
          // Confirming tap that ends before, at or after the deadline.
          rem = arm_t + cw - clock_ms;
          if (rem[31]) rem = 32'd0;
          queue_tap(b, near_value(rem));
        end
        2:       queue_tap(other, $urandom_range(0, lng / 2));
        default: ;
      endcase
    end
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    while (sample_queue.size() != 0 || in_valid_i || expected_events.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // Registers are only written while nothing is in flight, so the predictor can
  // take the new value at once.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    case (idx)
      REG_LONG_PRESS:     active_cfg.long_press_ms   = val;
      REG_DOUBLE_PRESS:   active_cfg.double_press_ms = val;
      REG_CONFIRM_WINDOW: active_cfg.confirm_span_ms = val;
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic write_all(input logic [CFG_W-1:0] lng, input logic [CFG_W-1:0] dbl,
                           input logic [CFG_W-1:0] cw);
    write_reg(REG_LONG_PRESS, lng);
    write_reg(REG_DOUBLE_PRESS, dbl);
    write_reg(REG_CONFIRM_WINDOW, cw);
  endtask

  task automatic report_result(input bit have_exp, input bgc_res_t exp, input bgc_res_t got);
    fail_count++;
    if (fail_count <= 10) begin
      if (!have_exp) begin
        $display("ERROR: result with nothing outstanding: ev %0d btn %0d ctl %0b can %0b pend %0b",
                 got.event_res, got.event_button, got.is_control_button,
                 got.confirm_cancelled, got.confirm_pending);
      end else begin
        $display("ERROR: result %0d expected ev %0d btn %0d ctl %0b can %0b pend %0b",
                 checked_results, exp.event_res, exp.event_button, exp.is_control_button,
                 exp.confirm_cancelled, exp.confirm_pending);
        $display("       got             ev %0d btn %0d ctl %0b can %0b pend %0b",
                 got.event_res, got.event_button, got.is_control_button,
                 got.confirm_cancelled, got.confirm_pending);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Request driver. The request under the handshake is run through the predictor
  // at the edge that accepts it; the next one follows after its drawn gap. The
  // valid is written once per edge, so back-to-back requests keep it high.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_req_i   <= '0;
      gap_count  <= 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        expected_events = {expected_events, classify_sample(in_req_i)};
        accepted_reqs++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (sample_queue.size() != 0 && gap_count >= sample_queue[0].gap) begin
          in_req_i   <= sample_queue[0].req;
          in_valid_i <= 1'b1;
          gap_count  <= 0;
          sample_queue.pop_front();
        end else begin
          in_valid_i <= 1'b0;
          if (sample_queue.size() != 0) gap_count <= gap_count + 1;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor. Every accepted result is checked field by field against the
  // oldest expectation; after each one the receiver may stall for a while.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      hold_left   <= 0;
    end else if (out_valid_o && !out_stall_i) begin
      if (expected_events.size() == 0) begin
        report_result(1'b0, '0, out_res_o);
      end else begin
        if (out_res_o.event_res !== expected_events[0].event_res ||
            out_res_o.event_button !== expected_events[0].event_button ||
            out_res_o.is_control_button !== expected_events[0].is_control_button ||
            out_res_o.confirm_cancelled !== expected_events[0].confirm_cancelled ||
            out_res_o.confirm_pending !== expected_events[0].confirm_pending) begin
          report_result(1'b1, expected_events[0], out_res_o);
        end
        event_tally[expected_events[0].event_res]++;
        if (expected_events[0].confirm_cancelled) cancel_tally++;
        expected_events.pop_front();
      end
      checked_results++;
      stall_draw = draw_wait();
      hold_left   <= stall_draw;
      out_stall_i <= (stall_draw != 0);
    end else if (hold_left > 0) begin
      out_stall_i <= (hold_left > 1);
      hold_left   <= hold_left - 1;
    end
  end

  // Watchdog: a run where neither channel moves for too long has hung.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      quiet_cycles <= 0;
    end else begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("ERROR: no handshake for %0d cycles", quiet_cycles);
        $display("CHECK FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer: reset, directed samples at the reset settings, then a random phase
  // per register setting. Phases with calm handshakes run at full rate.
  // ---------------------------------------------------------------------------
  initial begin
    fail_count   = 0;
    calm_phase   = 1'b0;
    reset_predictor();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    queue_directed();
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      if (phase != 0) begin
        wait_idle();
        case (phase)
          1: begin
            // Everything zero; the spare index must not disturb any register.
            write_all(16'd0, 16'd0, 16'd0);
            write_reg(REG_SPARE, 16'($urandom));
          end
          2:       write_all(16'hFFFF, 16'hFFFF, 16'hFFFF);
          3:       write_all(16'd40, 16'd25, 16'd150);
          4:       write_all($urandom_range(0, 2000), $urandom_range(0, 2000),
                             $urandom_range(0, 4000));
          5:       write_all(16'($urandom), 16'($urandom), 16'($urandom));
          default: write_all(LONG_PRESS_RESET, DOUBLE_PRESS_RESET, CONFIRM_WINDOW_RESET);
        endcase
        @(negedge clk_i);
      end
      calm_phase    = (phase == 2 || phase == 5);
      planned_count = 0;
      while (planned_count < PHASE_ITEMS) queue_gesture();
    end
    wait_idle();
    fail_count += expected_events.size();
    $display("Ran %0d requests and checked %0d results over %0d register settings.",
             accepted_reqs, checked_results, NUM_PHASES);
    $display("Seen: %0d presses, %0d arms, %0d confirms, %0d doubles, %0d singles, %0d cancels.",
             event_tally[EV_PRESS], event_tally[EV_LONG_ARM], event_tally[EV_LONG_CONF],
             event_tally[EV_DOUBLE], event_tally[EV_SINGLE], cancel_tally);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: button_gesture_classifier.f
rtl/bgc_pkg.sv
rtl/bgc_step.sv
rtl/button_gesture_classifier.sv
tb/sv/testbench.sv
